>>> rtl/cnm_pkg.sv
// Shared constants and types for the cosine nearest match core.
package cnm_pkg;

    localparam int GALLERY_DEPTH_DEF = 256;
    localparam int FEATURE_DIM_DEF   = 512;

    localparam logic signed [15:0] THRESH_RESET = 16'sd16384;
    localparam logic signed [15:0] COS_MIN      = -16'sd32768;
    localparam logic signed [15:0] COS_MAX      = 16'sd32767;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

endpackage

>>> rtl/cosine_nearest_match_core.sv
// Top level: gallery of feature vectors and cosine nearest-match search.
//
//  port group   dir  fields (lowest bit first)
//  s_*          in   tdata: operation, entry_index, element_index, element_value;
//                    tlast: last_element
//  m_*          out  tdata: matched, best_valid, best_index, best_cosine
//  cfg_*        in   match_threshold (signed Q1.15)
//
// Load items and non-last query elements are written directly into memory.
// A last query element starts a scan over every gallery entry: an entry of
// other length is skipped, one of equal length with a zero norm stops after
// the MAC, and any other runs the MAC over the gallery memory port, bit-serial
// square roots and a bit-serial divide. The result is then registered in S_OUT.
// No item is accepted during the scan.
// The result sits in an output register; the scan end waits if it is full.
// Reset runs a clearing pass over every entry of the length memory;
// no item is accepted until it ends.
module cosine_nearest_match_core
    import cnm_pkg::*;
#(
    parameter int GALLERY_DEPTH = GALLERY_DEPTH_DEF,
    parameter int FEATURE_DIM   = FEATURE_DIM_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation, entry_index, element_index, element_value
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // matched, best_valid, best_index, best_cosine
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    localparam int GI_W   = (GALLERY_DEPTH > 1) ? $clog2(GALLERY_DEPTH) : 1;
    localparam int FI_W   = (FEATURE_DIM > 1) ? $clog2(FEATURE_DIM) : 1;
    localparam int LEN_W  = $clog2(FEATURE_DIM + 1);
    localparam int GSZ    = GALLERY_DEPTH * FEATURE_DIM;
    localparam int GA_W   = (GSZ > 1) ? $clog2(GSZ) : 1;
    localparam int ACC_W  = 33 + $clog2(FEATURE_DIM);
    localparam int RT_W   = (ACC_W + 1) / 2;
    localparam int SQ_W   = 2 * RT_W;
    localparam int DEN_W  = 2 * RT_W;
    localparam int NUM_W  = ACC_W + 15;
    localparam int DV_W   = ((NUM_W > DEN_W + 17) ? NUM_W : DEN_W + 17) + 1;
    localparam int SQC_W  = $clog2(RT_W + 1);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_LREAD, S_LCHK, S_MAC, S_DRAIN, S_SQRT,
        S_MUL, S_DINIT, S_DIV, S_CMP, S_NEXT, S_OUT
    } state_t;

    // ---- input unpacking
    logic [1:0]         in_op;
    logic [7:0]         in_entry;
    logic [8:0]         in_elem;
    logic [15:0]        in_value;
    logic [GI_W+7:0]    entry_wide;
    logic [LEN_W+8:0]   elem_wide;
    logic               entry_ok, elem_ok, accept;
    logic [GI_W-1:0]    entry_addr;
    logic [FI_W-1:0]    elem_addr;
    logic [LEN_W-1:0]   elem_len;

    assign in_op      = s_tdata[1:0];
    assign in_entry   = s_tdata[9:2];
    assign in_elem    = s_tdata[18:10];
    assign in_value   = s_tdata[34:19];
    assign entry_wide = {{GI_W{1'b0}}, in_entry};
    assign elem_wide  = {{LEN_W{1'b0}}, in_elem};
    assign entry_ok   = entry_wide < (GI_W+8)'(GALLERY_DEPTH);
    assign elem_ok    = elem_wide < (LEN_W+9)'(FEATURE_DIM);
    assign entry_addr = entry_wide[GI_W-1:0];
    assign elem_addr  = elem_wide[FI_W-1:0];
    assign elem_len   = elem_wide[LEN_W-1:0] + LEN_W'(1);

    state_t state_reg;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    logic g_we, q_we, l_we;
    assign g_we = accept && (in_op == OP_WRITE) && entry_ok && elem_ok;
    assign q_we = accept && (in_op == OP_QUERY) && elem_ok;
    assign l_we = (g_we && s_tlast) || (accept && (in_op == OP_CLEAR) && entry_ok);

    // ---- scan registers
    logic [GI_W-1:0]        g_reg;
    logic [GA_W-1:0]        base_reg;
    logic [LEN_W-1:0]       qlen_reg, i_reg;
    logic                   rdv_reg, pv_reg;
    logic signed [31:0]     pdot_reg;
    logic [30:0]            pg_reg, pq_reg;
    logic signed [ACC_W-1:0] dot_reg;
    logic [ACC_W-1:0]       ng_reg, nq_reg, mag_reg;
    logic [SQ_W-1:0]        sng_reg, snq_reg, rg_reg, rq_reg, sbit_reg;
    logic [SQC_W-1:0]       sq_cnt_reg;
    logic [DEN_W-1:0]       den_reg;
    logic [DV_W-1:0]        rem_reg, dsh_reg;
    logic [16:0]            q_reg;
    logic                   ovf_reg;
    logic [4:0]             dv_cnt_reg;
    logic signed [15:0]     best_reg;
    logic [GI_W-1:0]        best_idx_reg;
    logic                   best_vld_reg;
    logic signed [15:0]     thresh_reg;
    logic                   m_tvalid_reg;
    logic [31:0]            m_tdata_reg;

    // ---- memories
    logic [15:0]      g_rd, q_rd;
    logic [LEN_W-1:0] l_rd;
    logic             mac_rd;
    logic [GA_W-1:0]  g_wr_addr;
    logic             init_we;
    logic [GI_W-1:0]  l_wr_addr;
    logic [LEN_W-1:0] l_wr_data;

    assign mac_rd    = (state_reg == S_MAC);
    assign g_wr_addr = GA_W'(entry_addr) * GA_W'(FEATURE_DIM) + GA_W'(elem_addr);

    // clearing pass after reset zeroes one length entry per cycle
    assign init_we   = (state_reg == S_INIT);
    assign l_wr_addr = init_we ? g_reg : entry_addr;
    assign l_wr_data = (!init_we && in_op == OP_WRITE) ? elem_len : '0;

    cnm_ram #(.WIDTH(16), .DEPTH(GSZ)) u_gallery (
        .aclk(aclk), .wr_en(g_we), .wr_addr(g_wr_addr), .wr_data(in_value),
        .rd_en(mac_rd), .rd_addr(base_reg + GA_W'(i_reg)), .rd_data(g_rd)
    );

    cnm_ram #(.WIDTH(16), .DEPTH(FEATURE_DIM)) u_query (
        .aclk(aclk), .wr_en(q_we), .wr_addr(elem_addr), .wr_data(in_value),
        .rd_en(mac_rd), .rd_addr(i_reg[FI_W-1:0]), .rd_data(q_rd)
    );

    cnm_ram #(.WIDTH(LEN_W), .DEPTH(GALLERY_DEPTH)) u_length (
        .aclk(aclk), .wr_en(l_we || init_we), .wr_addr(l_wr_addr),
        .wr_data(l_wr_data),
        .rd_en(state_reg == S_LREAD), .rd_addr(g_reg), .rd_data(l_rd)
    );

    // ---- one step of each square root
    logic [SQ_W-1:0] tg, tq;
    logic            geg, geq;
    assign tg  = rg_reg + sbit_reg;
    assign tq  = rq_reg + sbit_reg;
    assign geg = sng_reg >= tg;
    assign geq = snq_reg >= tq;

    // ---- divide step and cosine select
    logic               dge;
    logic signed [15:0] cos_val;
    logic               dot_neg;
    assign dge     = rem_reg >= dsh_reg;
    assign dot_neg = dot_reg[ACC_W-1];

    always_comb begin
        if (dot_neg) begin
            cos_val = (ovf_reg || q_reg >= 17'd32768) ? COS_MIN : -$signed({1'b0, q_reg[14:0]});
        end else begin
            cos_val = (ovf_reg || q_reg >= 17'd32767) ? COS_MAX : $signed({1'b0, q_reg[14:0]});
        end
    end

    logic [7:0] best_idx8;
    logic [GI_W+7:0] best_idx_wide;
    assign best_idx_wide = {8'd0, best_idx_reg};
    assign best_idx8     = best_idx_wide[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            g_reg        <= '0;
            thresh_reg   <= THRESH_RESET;
            m_tvalid_reg <= 1'b0;
            rdv_reg      <= 1'b0;
            pv_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                thresh_reg <= $signed(cfg_wr_data);
            end
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            // MAC pipeline: read data -> products -> accumulators
            rdv_reg <= mac_rd;
            pv_reg  <= rdv_reg;
            if (rdv_reg) begin
                pdot_reg <= $signed(g_rd) * $signed(q_rd);
                pg_reg   <= 31'($signed(g_rd) * $signed(g_rd));
                pq_reg   <= 31'($signed(q_rd) * $signed(q_rd));
            end
            if (pv_reg) begin
                dot_reg <= dot_reg + {{(ACC_W-32){pdot_reg[31]}}, pdot_reg};
                ng_reg  <= ng_reg + ACC_W'(pg_reg);
                nq_reg  <= nq_reg + ACC_W'(pq_reg);
            end

            case (state_reg)
                S_INIT: begin
                    if (g_reg == GI_W'(GALLERY_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end else begin
                        g_reg <= g_reg + GI_W'(1);
                    end
                end
                S_IDLE: begin
                    if (q_we && s_tlast) begin
                        qlen_reg     <= elem_len;
                        g_reg        <= '0;
                        base_reg     <= '0;
                        best_reg     <= COS_MIN;
                        best_idx_reg <= '0;
                        best_vld_reg <= 1'b0;
                        state_reg    <= S_LREAD;
                    end
                end
                S_LREAD: begin
                    state_reg <= S_LCHK;
                end
                S_LCHK: begin
                    if (l_rd == qlen_reg) begin
                        i_reg     <= '0;
                        dot_reg   <= '0;
                        ng_reg    <= '0;
                        nq_reg    <= '0;
                        state_reg <= S_MAC;
                    end else begin
                        state_reg <= S_NEXT;
                    end
                end
                S_MAC: begin
                    i_reg <= i_reg + LEN_W'(1);
                    if (i_reg == qlen_reg - LEN_W'(1)) begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!rdv_reg && !pv_reg) begin
                        if (ng_reg == '0 || nq_reg == '0) begin
                            state_reg <= S_NEXT;   // zero norm: cosine -1, never a best
                        end else begin
                            sng_reg    <= SQ_W'(ng_reg);
                            snq_reg    <= SQ_W'(nq_reg);
                            rg_reg     <= '0;
                            rq_reg     <= '0;
                            sbit_reg   <= SQ_W'(1) << (SQ_W - 2);
                            sq_cnt_reg <= '0;
                            mag_reg    <= dot_neg ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
                            state_reg  <= S_SQRT;
                        end
                    end
                end
                S_SQRT: begin
                    if (geg) begin
                        sng_reg <= sng_reg - tg;
                        rg_reg  <= (rg_reg >> 1) + sbit_reg;
                    end else begin
                        rg_reg  <= rg_reg >> 1;
                    end
                    if (geq) begin
                        snq_reg <= snq_reg - tq;
                        rq_reg  <= (rq_reg >> 1) + sbit_reg;
                    end else begin
                        rq_reg  <= rq_reg >> 1;
                    end
                    sbit_reg   <= sbit_reg >> 2;
                    sq_cnt_reg <= sq_cnt_reg + SQC_W'(1);
                    if (sq_cnt_reg == SQC_W'(RT_W - 1)) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    den_reg   <= rg_reg[RT_W-1:0] * rq_reg[RT_W-1:0];
                    state_reg <= S_DINIT;
                end
                S_DINIT: begin
                    rem_reg    <= DV_W'(mag_reg) << 15;
                    dsh_reg    <= DV_W'(den_reg) << 17;
                    q_reg      <= '0;
                    ovf_reg    <= 1'b0;
                    dv_cnt_reg <= '0;
                    state_reg  <= S_DIV;
                end
                S_DIV: begin
                    if (dv_cnt_reg == 5'd0) begin
                        ovf_reg <= dge;      // quotient would not fit 17 bits
                    end else begin
                        q_reg <= {q_reg[15:0], dge};
                        if (dge) begin
                            rem_reg <= rem_reg - dsh_reg;
                        end
                    end
                    dsh_reg    <= dsh_reg >> 1;
                    dv_cnt_reg <= dv_cnt_reg + 5'd1;
                    if (dv_cnt_reg == 5'd17) begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (cos_val > best_reg) begin
                        best_reg     <= cos_val;
                        best_idx_reg <= g_reg;
                        best_vld_reg <= 1'b1;
                    end
                    state_reg <= S_NEXT;
                end
                S_NEXT: begin
                    if (g_reg == GI_W'(GALLERY_DEPTH - 1)) begin
                        state_reg <= S_OUT;
                    end else begin
                        g_reg     <= g_reg + GI_W'(1);
                        base_reg  <= base_reg + GA_W'(FEATURE_DIM);
                        state_reg <= S_LREAD;
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {6'd0, best_reg, best_idx8, best_vld_reg,
                                         best_vld_reg && (best_reg >= thresh_reg)};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---- assertions
    a_mac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MAC |-> i_reg < qlen_reg)
        else $error("MAC index past query length");

    a_pipe_ctx: assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> (state_reg == S_MAC || state_reg == S_DRAIN))
        else $error("gallery read data outside MAC");

    a_den_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> den_reg != '0)
        else $error("zero divisor in cosine divide");

    a_match_vld: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (!m_tdata_reg[0] || m_tdata_reg[1]))
        else $error("match without a best entry");

endmodule

>>> rtl/cnm_ram.sv
// Generic simple dual-port RAM with registered read.
module cnm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
